/* hw/rtl/rbl_pkg.sv */
// Shared types and constants for the restart budget limiter.
// Holds the configuration and result structs, register indexes and defaults.
// No dependencies.
package rbl_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SHIFT_LIMIT = 32;

    localparam logic [7:0]  DEFAULT_BUDGET_C   = 8'd5;
    localparam logic [31:0] DEFAULT_WINDOW_S_C = 32'd60;
    localparam logic [31:0] DEFAULT_BASE_MS_C  = 32'd100;
    localparam logic [31:0] DEFAULT_CAP_MS_C   = 32'd10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_BUDGET = 3'd1,
        REG_WINDOW = 3'd2,
        REG_BASE   = 3'd3,
        REG_CAP    = 3'd4
    } rbl_reg_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  restart_budget;
        logic [31:0] window_seconds;
        logic [31:0] backoff_base_ms;
        logic [31:0] backoff_cap_ms;
    } rbl_cfg_t;

    typedef struct packed {
        logic        restart_granted;
        logic [7:0]  restart_count;
        logic [31:0] backoff_ms;
    } rbl_res_t;

endpackage

/* hw/rtl/rbl_step.sv */
// Per-event decision logic: window check, grant, count update and backoff.
// Purely combinational; depends on rbl_pkg.
module rbl_step #(
    parameter logic [7:0]  DEFAULT_BUDGET   = rbl_pkg::DEFAULT_BUDGET_C,
    parameter logic [31:0] DEFAULT_WINDOW_S = rbl_pkg::DEFAULT_WINDOW_S_C,
    parameter logic [31:0] DEFAULT_BASE_MS  = rbl_pkg::DEFAULT_BASE_MS_C,
    parameter logic [31:0] DEFAULT_CAP_MS   = rbl_pkg::DEFAULT_CAP_MS_C
) (
    input  rbl_pkg::rbl_cfg_t cfg,
    input  logic [7:0]        count,
    input  logic [31:0]       open_time,
    input  logic [31:0]       now_seconds,
    input  logic              orderly_exit,
    output logic [7:0]        count_next,
    output logic [31:0]       open_time_next,
    output rbl_pkg::rbl_res_t res
);
    import rbl_pkg::*;

    logic        active;
    logic [7:0]  budget;
    logic [31:0] win;
    logic [31:0] elapsed;
    logic        open_new;
    logic [7:0]  count_base;
    logic        grant;
    logic [31:0] base;
    logic [31:0] cap_raw;
    logic [31:0] cap;
    logic [7:0]  expo;
    logic [63:0] shifted;

    always_comb
    begin
        active   = cfg.enable && !orderly_exit;
        budget   = (cfg.restart_budget != 8'd0) ? cfg.restart_budget : DEFAULT_BUDGET;
        win      = (cfg.window_seconds != 32'd0) ? cfg.window_seconds : DEFAULT_WINDOW_S;
        elapsed  = now_seconds - open_time;
        open_new = (count == 8'd0) || (now_seconds < open_time) || (elapsed >= win);

        count_base = open_new ? 8'd0 : count;
        grant      = active && (count_base < budget);

        if (active)
        begin
            count_next     = grant ? (count_base + 8'd1) : count_base;
            open_time_next = open_new ? now_seconds : open_time;
        end
        else
        begin
            count_next     = count;
            open_time_next = open_time;
        end

        base    = (cfg.backoff_base_ms != 32'd0) ? cfg.backoff_base_ms : DEFAULT_BASE_MS;
        cap_raw = (cfg.backoff_cap_ms != 32'd0) ? cfg.backoff_cap_ms : DEFAULT_CAP_MS;
        cap     = (cap_raw < base) ? base : cap_raw;
        expo    = (count_next != 8'd0) ? (count_next - 8'd1) : 8'd0;
        shifted = {32'd0, base} << expo[4:0];

        res.restart_granted = grant;
        res.restart_count   = count_next;
        if (expo >= 8'(SHIFT_LIMIT))
        begin
            res.backoff_ms = cap;
        end
        else if (shifted < {32'd0, cap})
        begin
            res.backoff_ms = shifted[31:0];
        end
        else
        begin
            res.backoff_ms = cap;
        end
    end

endmodule

/* hw/rtl/restart_budget_limiter_with_backoff.sv */
// Restart budget limiter top level: config registers, input and result stages.
// Depends on rbl_pkg and rbl_step.
//
// Each crash event enters an input register, is decided against the current window
// state, and lands in a result register; one event per clock is sustained while the
// output does not stall. An event passes through the two register stages, the input
// register and then the result register, before its result can leave. The result
// register and the input register each take a new transaction while the stage
// downstream drains, so a stalled output only blocks input once both are full.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and should change
// only while no event is in flight; zero in the budget, window, base or cap register selects its default.
module restart_budget_limiter_with_backoff #(
    parameter logic [7:0]  DEFAULT_BUDGET   = rbl_pkg::DEFAULT_BUDGET_C,
    parameter logic [31:0] DEFAULT_WINDOW_S = rbl_pkg::DEFAULT_WINDOW_S_C,
    parameter logic [31:0] DEFAULT_BASE_MS  = rbl_pkg::DEFAULT_BASE_MS_C,
    parameter logic [31:0] DEFAULT_CAP_MS   = rbl_pkg::DEFAULT_CAP_MS_C
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rbl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rbl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] now_seconds
    input  logic                            s_axis_tuser,  // [0] orderly_exit
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // [7:0] restart_count,
                                                           // [39:8] backoff_ms
    output logic                            m_axis_tuser   // [0] restart_granted
);
    import rbl_pkg::*;

    rbl_cfg_t    cfg_reg;
    logic [7:0]  count_reg;
    logic [31:0] open_time_reg;
    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic        in_clean_reg;
    logic        out_valid_reg;
    rbl_res_t    out_res_reg;

    logic [7:0]  count_next;
    logic [31:0] open_time_next;
    rbl_res_t    res_next;
    logic        out_ready;
    logic        advance;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ENABLE: cfg_reg.enable          <= cfg_wdata[0];
                REG_BUDGET: cfg_reg.restart_budget  <= cfg_wdata[7:0];
                REG_WINDOW: cfg_reg.window_seconds  <= cfg_wdata[31:0];
                REG_BASE:   cfg_reg.backoff_base_ms <= cfg_wdata[31:0];
                REG_CAP:    cfg_reg.backoff_cap_ms  <= cfg_wdata[31:0];
                default:    cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    rbl_step #(
        .DEFAULT_BUDGET   (DEFAULT_BUDGET),
        .DEFAULT_WINDOW_S (DEFAULT_WINDOW_S),
        .DEFAULT_BASE_MS  (DEFAULT_BASE_MS),
        .DEFAULT_CAP_MS   (DEFAULT_CAP_MS)
    ) u_step (
        .cfg            (cfg_reg),
        .count          (count_reg),
        .open_time      (open_time_reg),
        .now_seconds    (in_now_reg),
        .orderly_exit   (in_clean_reg),
        .count_next     (count_next),
        .open_time_next (open_time_next),
        .res            (res_next)
    );

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= 8'd0;
            open_time_reg <= 32'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                count_reg     <= count_next;
                open_time_reg <= open_time_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_now_reg   <= s_axis_tdata;
            in_clean_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.backoff_ms, out_res_reg.restart_count};
    assign m_axis_tuser  = out_res_reg.restart_granted;

    a_grant_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] != 8'd0))
        else $error("granted result with zero count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 8'd1)
            || (count_reg == 8'd1)))
        else $error("window count moved by more than one grant");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(open_time_reg)))
        else $error("window state changed without an event");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled while a stage was empty");

endmodule
